// ----- rtl/shape_pair_collision_test_top_assert.svh -----
// assertion macros for the shape pair collision test
// used by shape_pair_collision_test_top; no other dependencies
`ifndef SHAPE_PAIR_COLLISION_TEST_TOP_ASSERT_SVH
`define SHAPE_PAIR_COLLISION_TEST_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define SPCT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SPCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPCT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define SPCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/spct_pkg.sv -----
// shared types and codes for the shape pair collision test
// no dependencies
package spct_pkg;

    // pair kind codes carried in tuser
    localparam logic [1:0] CMD_RECT_RECT = 2'd0;
    localparam logic [1:0] CMD_RECT_CIRC = 2'd1;
    localparam logic [1:0] CMD_CIRC_CIRC = 2'd2;

    // load enables for the two register stages of a squaring lane
    typedef struct packed {
        logic en_pp;
        logic en_sq;
    } t_lane_ctl;

endpackage

// ----- rtl/shape_pair_collision_test_top.sv -----
// throughput: one shape pair per cycle while the output accepts; an accepted input beat
// passes stages 1 to 6 in order; each stage loads when empty or when the next moves
// a stalled output only holds the stages that are full; bubbles upstream keep filling
// reset clears the stage valid bits only; data registers are not reset
// shape pair collision test top: edges, compares, squares and final hit over six stages
// depends on spct_pkg, spct_sq_lane and shape_pair_collision_test_top_assert.svh
module shape_pair_collision_test_top
    import spct_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    // a_x, a_y, a_size_x, a_size_y, b_x, b_y, b_size_x, b_size_y, zero pad
    input  logic [((8*COORD_BITS-4+7)/8)*8-1:0] s_axis_tdata,
    // command
    input  logic [1:0]      s_axis_tuser,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    // hit, zero pad
    output logic [7:0]      m_axis_tdata
);

    localparam int C  = COORD_BITS;
    localparam int SB = C - 1;          // size field width
    localparam int EW = C + 1;          // edge width, signed
    localparam int DF = C + 2;          // difference width, signed
    localparam int ML = C + 1;          // magnitude width
    localparam int SW = 2 * ML;         // square width
    localparam int DW = SW + 1;         // sum of two squares

    localparam int OFS_AX  = 0;
    localparam int OFS_AY  = OFS_AX + C;
    localparam int OFS_ASX = OFS_AY + C;
    localparam int OFS_ASY = OFS_ASX + SB;
    localparam int OFS_BX  = OFS_ASY + SB;
    localparam int OFS_BY  = OFS_BX + C;
    localparam int OFS_BSX = OFS_BY + C;
    localparam int OFS_BSY = OFS_BSX + SB;

    // stage handshake
    logic       r_v [1:6];
    logic [1:7] rdy;

    // input unpack
    logic [C-1:0]  w_ax, w_ay, w_bx, w_by;
    logic [SB-1:0] w_asx, w_asy, w_bsx, w_bsy;

    // stage 1
    logic [1:0]           r_kind [1:5];
    logic signed [EW-1:0] r_ax0, r_ax1, r_ay0, r_ay1;
    logic signed [EW-1:0] r_bx0, r_bx1, r_by0, r_by1;
    logic [C-1:0]         r_cx, r_cy;
    logic [C-1:0]         r_rad;
    logic signed [EW-1:0] n_ax0, n_ax1, n_ay0, n_ay1;
    logic signed [EW-1:0] n_bx0, n_bx1, n_by0, n_by1;
    logic [C-1:0]         n_rad;
    logic signed [EW-1:0] w_ax_e, w_ay_e, w_bx_e, w_by_e;
    logic signed [EW-1:0] w_ahx, w_ahy, w_asub_x, w_asub_y, w_bsub_x, w_bsub_y;

    // stage 2
    logic                 r_box  [2:5];
    logic                 r_band [2:5];
    logic [ML-1:0]        r_mag  [0:4];
    logic                 n_box, n_band;
    logic [ML-1:0]        n_mag  [0:4];
    logic signed [EW-1:0] w_cx_e, w_cy_e;
    logic signed [EW-1:0] w_opa [0:3];
    logic signed [EW-1:0] w_opb [0:3];
    logic signed [DF-1:0] w_dp  [0:3];
    logic signed [DF-1:0] w_dq  [0:3];

    // stages 3 and 4 live in the squaring lanes
    t_lane_ctl            w_lane_ctl;
    logic [SW-1:0]        w_sq [0:4];

    // stage 5
    logic [DW-1:0]        r_cd [0:3];
    logic [DW-1:0]        r_r2;

    // stage 6
    logic                 r_hit;
    logic                 n_hit;
    logic                 w_corner;

    // per-stage ready: a stage loads when empty or when the one after it moves
    always_comb begin
        rdy[7] = m_axis_tready;
        for (int k = 6; k >= 1; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign s_axis_tready = rdy[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= 6; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            if (rdy[1]) begin
                r_v[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= 6; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ---------------- stage 1: edges ----------------
    assign w_ax  = s_axis_tdata[OFS_AX  +: C];
    assign w_ay  = s_axis_tdata[OFS_AY  +: C];
    assign w_asx = s_axis_tdata[OFS_ASX +: SB];
    assign w_asy = s_axis_tdata[OFS_ASY +: SB];
    assign w_bx  = s_axis_tdata[OFS_BX  +: C];
    assign w_by  = s_axis_tdata[OFS_BY  +: C];
    assign w_bsx = s_axis_tdata[OFS_BSX +: SB];
    assign w_bsy = s_axis_tdata[OFS_BSY +: SB];

    always_comb begin
        w_ax_e = {w_ax[C-1], w_ax};
        w_ay_e = {w_ay[C-1], w_ay};
        w_bx_e = {w_bx[C-1], w_bx};
        w_by_e = {w_by[C-1], w_by};
        w_ahx  = {3'b000, w_asx[SB-1:1]};
        w_ahy  = {3'b000, w_asy[SB-1:1]};
        // circle pairs keep the raw center in the low edge slot
        w_asub_x = (s_axis_tuser == CMD_CIRC_CIRC) ? {EW{1'b0}} : w_ahx;
        w_asub_y = (s_axis_tuser == CMD_CIRC_CIRC) ? {EW{1'b0}} : w_ahy;
        // circle b uses its bounding square, half size equal to the radius
        w_bsub_x = (s_axis_tuser == CMD_RECT_RECT) ? {3'b000, w_bsx[SB-1:1]}
                                                   : {2'b00, w_bsx};
        w_bsub_y = (s_axis_tuser == CMD_RECT_RECT) ? {3'b000, w_bsy[SB-1:1]}
                                                   : {2'b00, w_bsx};
        n_ax0 = w_ax_e - w_asub_x;
        n_ax1 = w_ax_e + w_ahx;
        n_ay0 = w_ay_e - w_asub_y;
        n_ay1 = w_ay_e + w_ahy;
        n_bx0 = w_bx_e - w_bsub_x;
        n_bx1 = w_bx_e + w_bsub_x;
        n_by0 = w_by_e - w_bsub_y;
        n_by1 = w_by_e + w_bsub_y;
        n_rad = (s_axis_tuser == CMD_CIRC_CIRC) ? ({1'b0, w_asx} + {1'b0, w_bsx})
                                                : {1'b0, w_bsx};
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_kind[1] <= s_axis_tuser;
            r_ax0     <= n_ax0;
            r_ax1     <= n_ax1;
            r_ay0     <= n_ay0;
            r_ay1     <= n_ay1;
            r_bx0     <= n_bx0;
            r_bx1     <= n_bx1;
            r_by0     <= n_by0;
            r_by1     <= n_by1;
            r_cx      <= w_bx;
            r_cy      <= w_by;
            r_rad     <= n_rad;
        end
    end

    // ---------------- stage 2: overlap, bands, magnitudes ----------------
    always_comb begin
        w_cx_e = {r_cx[C-1], r_cx};
        w_cy_e = {r_cy[C-1], r_cy};
        n_box  = !((r_ax1 < r_bx0) || (r_ax0 > r_bx1) ||
                   (r_ay1 < r_by0) || (r_ay0 > r_by1));
        n_band = ((w_cx_e < r_ax1) && (w_cx_e > r_ax0)) ||
                 ((w_cy_e < r_ay1) && (w_cy_e > r_ay0));
        w_opa[0] = w_cx_e;  w_opb[0] = r_ax0;
        w_opa[1] = w_cx_e;  w_opb[1] = r_ax1;
        w_opa[2] = w_cy_e;  w_opb[2] = r_ay0;
        w_opa[3] = w_cy_e;  w_opb[3] = r_ay1;
        // both differences side by side, pick the non-negative one
        for (int i = 0; i < 4; i++) begin
            w_dp[i]  = {w_opa[i][EW-1], w_opa[i]} - {w_opb[i][EW-1], w_opb[i]};
            w_dq[i]  = {w_opb[i][EW-1], w_opb[i]} - {w_opa[i][EW-1], w_opa[i]};
            n_mag[i] = w_dp[i][DF-1] ? w_dq[i][ML-1:0] : w_dp[i][ML-1:0];
        end
        n_mag[4] = {1'b0, r_rad};
    end

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r_kind[2] <= r_kind[1];
            r_box[2]  <= n_box;
            r_band[2] <= n_band;
            for (int i = 0; i < 5; i++) begin
                r_mag[i] <= n_mag[i];
            end
        end
    end

    // ---------------- stages 3 and 4: squares ----------------
    assign w_lane_ctl.en_pp = rdy[3];
    assign w_lane_ctl.en_sq = rdy[4];

    for (genvar g = 0; g < 5; g++) begin : g_lane
        spct_sq_lane #(
            .MAG_BITS (ML)
        ) u_sq_lane (
            .i_clk  (i_clk),
            .i_ctl  (w_lane_ctl),
            .i_mag  (r_mag[g]),
            .o_sq   (w_sq[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r_kind[3] <= r_kind[2];
            r_box[3]  <= r_box[2];
            r_band[3] <= r_band[2];
        end
        if (rdy[4]) begin
            r_kind[4] <= r_kind[3];
            r_box[4]  <= r_box[3];
            r_band[4] <= r_band[3];
        end
    end

    // ---------------- stage 5: corner distances ----------------
    // lanes: 0 dx to x0, 1 dx to x1, 2 dy to y0, 3 dy to y1, 4 radius
    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            r_kind[5] <= r_kind[4];
            r_box[5]  <= r_box[4];
            r_band[5] <= r_band[4];
            r_cd[0]   <= {1'b0, w_sq[0]} + {1'b0, w_sq[2]};
            r_cd[1]   <= {1'b0, w_sq[1]} + {1'b0, w_sq[3]};
            r_cd[2]   <= {1'b0, w_sq[0]} + {1'b0, w_sq[3]};
            r_cd[3]   <= {1'b0, w_sq[1]} + {1'b0, w_sq[2]};
            r_r2      <= {1'b0, w_sq[4]};
        end
    end

    // ---------------- stage 6: decision ----------------
    always_comb begin
        w_corner = (r_r2 > r_cd[0]) || (r_r2 > r_cd[1]) ||
                   (r_r2 > r_cd[2]) || (r_r2 > r_cd[3]);
        unique case (r_kind[5])
            CMD_RECT_RECT: n_hit = r_box[5];
            CMD_RECT_CIRC: n_hit = r_box[5] && (r_band[5] || w_corner);
            // center distance sits in the first corner slot
            CMD_CIRC_CIRC: n_hit = r_r2 > r_cd[0];
            default:       n_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy[6]) begin
            r_hit <= n_hit;
        end
    end

    assign m_axis_tvalid = r_v[6];
    assign m_axis_tdata  = {7'b0000000, r_hit};

    `include "shape_pair_collision_test_top_assert.svh"

    `SPCT_ASSERT_SAME(a_ready_when_out_empty, i_clk, i_rst_n, !r_v[6], s_axis_tready, "input stalled with empty output stage")
    `SPCT_ASSERT_NEXT(a_accept_enters_pipe, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_v[1], "accepted beat lost at stage 1")
    `SPCT_ASSERT_NEXT(a_no_box_no_hit, i_clk, i_rst_n, rdy[6] && r_v[5] && (r_kind[5] != CMD_CIRC_CIRC) && !r_box[5], !r_hit, "hit without box overlap")
    `SPCT_ASSERT_NEXT(a_band_hit, i_clk, i_rst_n, rdy[6] && r_v[5] && (r_kind[5] == CMD_RECT_CIRC) && r_box[5] && r_band[5], r_hit, "band inclusion missed")

endmodule

// ----- rtl/spct_sq_lane.sv -----
// two-stage pipelined squarer: split partial products, then their sum
// depends on spct_pkg for the stage enable struct
module spct_sq_lane
    import spct_pkg::*;
#(
    parameter int MAG_BITS = 33
) (
    input  logic                    i_clk,
    input  t_lane_ctl               i_ctl,
    input  logic [MAG_BITS-1:0]     i_mag,
    output logic [2*MAG_BITS-1:0]   o_sq
);

    localparam int LO_BITS = (MAG_BITS + 1) / 2;
    localparam int HI_BITS = MAG_BITS - LO_BITS;
    localparam int SQ_BITS = 2 * MAG_BITS;

    logic [HI_BITS-1:0]         w_hi;
    logic [LO_BITS-1:0]         w_lo;
    logic [2*HI_BITS-1:0]       w_hi_hh;
    logic [2*LO_BITS-1:0]       w_lo_ll;
    logic [MAG_BITS-1:0]        w_hi_hl;
    logic [MAG_BITS-1:0]        w_lo_hl;

    logic [2*HI_BITS-1:0]       r_hh;
    logic [MAG_BITS-1:0]        r_hl;
    logic [2*LO_BITS-1:0]       r_ll;
    logic [SQ_BITS-1:0]         r_sq;
    logic [SQ_BITS-1:0]         n_sq;

    assign w_lo    = i_mag[LO_BITS-1:0];
    assign w_hi    = i_mag[MAG_BITS-1:LO_BITS];
    assign w_hi_hh = {{HI_BITS{1'b0}}, w_hi};
    assign w_lo_ll = {{LO_BITS{1'b0}}, w_lo};
    assign w_hi_hl = {{LO_BITS{1'b0}}, w_hi};
    assign w_lo_hl = {{HI_BITS{1'b0}}, w_lo};

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_pp) begin
            r_hh <= w_hi_hh * w_hi_hh;
            r_hl <= w_hi_hl * w_lo_hl;
            r_ll <= w_lo_ll * w_lo_ll;
        end
    end

    // m^2 = hi^2 * 2^(2L) + hi*lo * 2^(L+1) + lo^2
    always_comb begin
        n_sq = {r_hh, {(2*LO_BITS){1'b0}}}
             + {{(HI_BITS-1){1'b0}}, r_hl, {(LO_BITS+1){1'b0}}}
             + {{(SQ_BITS-2*LO_BITS){1'b0}}, r_ll};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_sq) begin
            r_sq <= n_sq;
        end
    end

    assign o_sq = r_sq;

endmodule
